>>> src/wtw_pkg.sv
package wtw_pkg;

	// Fixed-point widths that follow from the field ranges alone.
	localparam int CORDIC_W  = 28;   // signed Q16 CORDIC vector, |v| < 2^26
	localparam int MAG_W     = 26;   // segment length in Q16
	localparam int HALF_W    = 13;   // half of the length multiplier operand
	localparam int GAIN_W    = 30;   // width of the inverse gain constant
	localparam int PROD_W    = HALF_W + GAIN_W;
	localparam int ACC_W     = MAG_W + GAIN_W + 1;
	localparam int DIST_W    = MAG_W + 12;
	localparam int SUM_W     = 40;   // wheel targets before truncation, Q24
	localparam int HQ30_W    = 34;   // heading in Q30, -pi/2 .. 3pi/2
	localparam int ATAN_W    = 31;
	localparam int TABLE_LEN = 24;
	localparam int TABLE_IW  = 5;
	localparam int TICKS_W   = 14;
	localparam int CFG_W     = 16;

	localparam logic [GAIN_W-1:0]        INV_GAIN_Q30 = 30'd652032874;
	localparam logic signed [HQ30_W-1:0] PI_Q30       = 34'sd3373259426;
	localparam logic signed [HQ30_W-1:0] HALF_PI_Q30  = 34'sd1686629713;
	localparam logic signed [SUM_W-1:0]  TICK_LIMIT   = 40'sd8191;

	localparam logic [11:0] DIST_SCALE_RESET = 12'd1434;
	localparam logic [15:0] TURN_SCALE_RESET = 16'd21504;

	typedef enum logic [0:0] {
		CFG_DIST_SCALE,
		CFG_TURN_SCALE
	} wtw_cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_MAG,
		ST_SCALE,
		ST_SUM,
		ST_FINISH
	} wtw_state_t;

	typedef struct packed {
		logic load;
		logic cordic_step;
		logic mul_lo;
		logic mul_hi;
		logic mag;
		logic scale;
		logic sum;
		logic finish;
	} wtw_cmd_t;

	typedef struct packed {
		logic start_pt;
		logic cordic_last;
		logic out_free;
	} wtw_sts_t;

	// atan(2^-i) in Q30.
	function automatic logic [ATAN_W-1:0] atan_q30(input logic [TABLE_IW-1:0] idx);
		logic [ATAN_W-1:0] v;
		unique case (idx)
			5'd0:  v = 31'd843314856;
			5'd1:  v = 31'd497837829;
			5'd2:  v = 31'd263043836;
			5'd3:  v = 31'd133525158;
			5'd4:  v = 31'd67021686;
			5'd5:  v = 31'd33543515;
			5'd6:  v = 31'd16775850;
			5'd7:  v = 31'd8388437;
			5'd8:  v = 31'd4194282;
			5'd9:  v = 31'd2097149;
			5'd10: v = 31'd1048576;
			5'd11: v = 31'd524288;
			5'd12: v = 31'd262144;
			5'd13: v = 31'd131072;
			5'd14: v = 31'd65536;
			5'd15: v = 31'd32768;
			5'd16: v = 31'd16384;
			5'd17: v = 31'd8192;
			5'd18: v = 31'd4096;
			5'd19: v = 31'd2048;
			5'd20: v = 31'd1024;
			5'd21: v = 31'd512;
			5'd22: v = 31'd256;
			5'd23: v = 31'd128;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

>>> src/wtw_in_if.sv
interface wtw_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] pos_x;
	logic [7:0] pos_y;
	logic       path_start;

	modport source (output valid, output pos_x, output pos_y, output path_start,
		input ready);
	modport sink (input valid, input pos_x, input pos_y, input path_start,
		output ready);
endinterface

>>> src/wtw_out_if.sv
interface wtw_out_if;
	logic               valid;
	logic               ready;
	logic signed [13:0] left_ticks;
	logic signed [13:0] right_ticks;
	logic               clipped;

	modport source (output valid, output left_ticks, output right_ticks, output clipped,
		input ready);
	modport sink (input valid, input left_ticks, input right_ticks, input clipped,
		output ready);
endinterface

>>> src/waypoint_to_wheel_ticks_core.sv
// Waypoint to wheel ticks.
// Screen waypoints enter on the waypoint channel, one word per point, and each
// segment from the previous point yields one word of left and right wheel tick
// targets on the ticks channel. A word with path_start set, or the first word
// after reset, only records the point and clears the heading; it yields nothing.
// A path-start word is taken and the block stays idle. A segment word passes
// in order through a load step, the CORDIC_STEPS steps (14 by default) of the
// shared vectoring CORDIC, the two halves of the length multiply, a step that
// combines them, and scaling, summing and rounding; only then can the next
// word be accepted, in the same cycle that its result word becomes valid. The
// result sits in an output register, so the next waypoint is taken while a
// result waits; if the receiver stalls, the following segment finishes and
// then holds until the register is free. dist_scale and turn_scale are
// written through cfg_wr_en, cfg_index and cfg_data; the user must do so only
// while the block is idle, which the block itself does not enforce. Reset
// clears the stored point and heading, restores the scale registers and
// empties the output register.
module waypoint_to_wheel_ticks_core #(
	parameter int CORDIC_STEPS    = 14,
	parameter int ANGLE_FRAC_BITS = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	wtw_in_if.sink                    waypoint,
	wtw_out_if.source                 ticks,
	input  logic                      cfg_wr_en,
	input  logic [0:0]                cfg_index,
	input  logic [wtw_pkg::CFG_W-1:0] cfg_data
);

	wtw_pkg::wtw_cmd_t cmd;
	wtw_pkg::wtw_sts_t sts;

	wtw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (waypoint.valid),
		.in_ready (waypoint.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wtw_datapath #(
		.CORDIC_STEPS    (CORDIC_STEPS),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.pos_x       (waypoint.pos_x),
		.pos_y       (waypoint.pos_y),
		.path_start  (waypoint.path_start),
		.out_ready   (ticks.ready),
		.out_valid   (ticks.valid),
		.left_ticks  (ticks.left_ticks),
		.right_ticks (ticks.right_ticks),
		.clipped     (ticks.clipped),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

>>> src/wtw_ctrl.sv
module wtw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  wtw_pkg::wtw_sts_t sts,
	output wtw_pkg::wtw_cmd_t cmd
);

	wtw_pkg::wtw_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wtw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			wtw_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					// A path start only records the point and yields no word.
					if (!sts.start_pt) begin
						state_d = wtw_pkg::ST_CORDIC;
					end
				end
			end
			wtw_pkg::ST_CORDIC: begin
				cmd.cordic_step = 1'b1;
				if (sts.cordic_last) begin
					state_d = wtw_pkg::ST_MUL_LO;
				end
			end
			wtw_pkg::ST_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_d    = wtw_pkg::ST_MUL_HI;
			end
			wtw_pkg::ST_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = wtw_pkg::ST_MAG;
			end
			wtw_pkg::ST_MAG: begin
				cmd.mag = 1'b1;
				state_d = wtw_pkg::ST_SCALE;
			end
			wtw_pkg::ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = wtw_pkg::ST_SUM;
			end
			wtw_pkg::ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = wtw_pkg::ST_FINISH;
			end
			wtw_pkg::ST_FINISH: begin
				// Wait here until the output register can take the word.
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = wtw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wtw_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> src/wtw_datapath.sv
module wtw_datapath #(
	parameter int CORDIC_STEPS    = 14,
	parameter int ANGLE_FRAC_BITS = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [7:0]                         pos_x,
	input  logic [7:0]                         pos_y,
	input  logic                               path_start,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic signed [wtw_pkg::TICKS_W-1:0] left_ticks,
	output logic signed [wtw_pkg::TICKS_W-1:0] right_ticks,
	output logic                               clipped,
	input  logic                               cfg_wr_en,
	input  logic [0:0]                         cfg_index,
	input  logic [wtw_pkg::CFG_W-1:0]          cfg_data,
	input  wtw_pkg::wtw_cmd_t                  cmd,
	output wtw_pkg::wtw_sts_t                  sts
);

	localparam int CNT_W = $clog2(CORDIC_STEPS);
	localparam int HW    = ANGLE_FRAC_BITS + 4;   // heading, -pi/2 .. 3pi/2
	localparam int DW    = HW + 1;                // heading change
	localparam int FW    = DW + 17;               // turn product
	localparam int CW    = wtw_pkg::CORDIC_W;
	localparam int SW    = wtw_pkg::SUM_W;

	// Configuration.
	logic [11:0] dist_scale_q;
	logic [15:0] turn_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_scale_q <= wtw_pkg::DIST_SCALE_RESET;
			turn_scale_q <= wtw_pkg::TURN_SCALE_RESET;
		end else if (cfg_wr_en) begin
			unique case (wtw_pkg::wtw_cfg_idx_t'(cfg_index))
				wtw_pkg::CFG_DIST_SCALE: dist_scale_q <= cfg_data[11:0];
				wtw_pkg::CFG_TURN_SCALE: turn_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Segment state kept between words.
	logic [7:0]           prev_x_q, prev_y_q;
	logic                 have_prev_q;
	logic signed [HW-1:0] last_heading_q;
	logic signed [HW-1:0] heading_q;

	logic signed [8:0] dx, dy;
	logic [7:0]        abs_dy;

	assign dx           = $signed({1'b0, pos_x}) - $signed({1'b0, prev_x_q});
	assign dy           = $signed({1'b0, pos_y}) - $signed({1'b0, prev_y_q});
	assign abs_dy       = dy[8] ? 8'(-dy) : dy[7:0];
	assign sts.start_pt = path_start || !have_prev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q       <= '0;
			prev_y_q       <= '0;
			have_prev_q    <= 1'b0;
			last_heading_q <= '0;
		end else begin
			if (cmd.load) begin
				prev_x_q    <= pos_x;
				prev_y_q    <= pos_y;
				have_prev_q <= 1'b1;
				if (sts.start_pt) begin
					last_heading_q <= '0;
				end
			end
			if (cmd.finish) begin
				last_heading_q <= heading_q;
			end
		end
	end

	// Vectoring CORDIC, one step a cycle.
	logic signed [CW-1:0]  cx_q, cy_q, sx, sy;
	logic signed [31:0]    ang_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [wtw_pkg::TABLE_IW-1:0] tab_idx;
	logic signed [31:0]    atan_v;
	logic dy_neg_q, dy_zero_q, dx_neg_q, dx_zero_q;

	assign tab_idx         = wtw_pkg::TABLE_IW'(cnt_q);
	assign atan_v          = $signed({1'b0, wtw_pkg::atan_q30(tab_idx)});
	assign sx              = cx_q >>> cnt_q;
	assign sy              = cy_q >>> cnt_q;
	assign sts.cordic_last = (cnt_q == CNT_W'(CORDIC_STEPS - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q      <= $signed({4'b0, abs_dy, 16'b0});
			cy_q      <= $signed({{3{dx[8]}}, dx, 16'b0});
			ang_q     <= '0;
			cnt_q     <= '0;
			dy_neg_q  <= dy[8];
			dy_zero_q <= (dy == 9'sd0);
			dx_neg_q  <= dx[8];
			dx_zero_q <= (dx == 9'sd0);
		end else if (cmd.cordic_step) begin
			if (cy_q > 0) begin
				cx_q  <= cx_q + sy;
				cy_q  <= cy_q - sx;
				ang_q <= ang_q + atan_v;
			end else begin
				cx_q  <= cx_q - sy;
				cy_q  <= cy_q + sx;
				ang_q <= ang_q - atan_v;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Heading from the quadrant, rounded to nearest with ties upward.
	logic signed [wtw_pkg::HQ30_W-1:0] hd_q30, hd_rnd, hd_sh;

	always_comb begin
		priority if (!dy_neg_q && !dy_zero_q) begin
			hd_q30 = wtw_pkg::HQ30_W'(ang_q);
		end else if (dy_neg_q) begin
			hd_q30 = wtw_pkg::PI_Q30 - wtw_pkg::HQ30_W'(ang_q);
		end else if (dx_zero_q) begin
			hd_q30 = '0;
		end else if (dx_neg_q) begin
			hd_q30 = -wtw_pkg::HALF_PI_Q30;
		end else begin
			hd_q30 = wtw_pkg::HALF_PI_Q30;
		end
	end

	assign hd_rnd = hd_q30 + (wtw_pkg::HQ30_W'(1) <<< (29 - ANGLE_FRAC_BITS));
	assign hd_sh  = hd_rnd >>> (30 - ANGLE_FRAC_BITS);

	// Length: the CORDIC x times 1/K, in two half-width products.
	logic [wtw_pkg::MAG_W-1:0]  cx_u;
	logic [wtw_pkg::HALF_W-1:0] mul_a;
	logic [wtw_pkg::PROD_W-1:0] prod_q, acc_q;
	logic [wtw_pkg::ACC_W-1:0]  mag_full;
	logic [wtw_pkg::MAG_W-1:0]  mag_q;
	logic signed [DW-1:0]       delta_q;

	assign cx_u     = cx_q[wtw_pkg::MAG_W-1:0];
	assign mul_a    = cmd.mul_hi ? cx_u[wtw_pkg::MAG_W-1:wtw_pkg::HALF_W]
	                             : cx_u[wtw_pkg::HALF_W-1:0];
	assign mag_full = wtw_pkg::ACC_W'(acc_q)
	                + wtw_pkg::ACC_W'({prod_q, {wtw_pkg::HALF_W{1'b0}}});

	always_ff @(posedge clk) begin
		if (cmd.mul_lo || cmd.mul_hi) begin
			prod_q <= wtw_pkg::PROD_W'(mul_a) * wtw_pkg::PROD_W'(wtw_pkg::INV_GAIN_Q30);
		end
		if (cmd.mul_lo) begin
			heading_q <= hd_sh[HW-1:0];
		end
		if (cmd.mul_hi) begin
			acc_q   <= prod_q;
			delta_q <= DW'(heading_q) - DW'(last_heading_q);
		end
		if (cmd.mag) begin
			mag_q <= mag_full[wtw_pkg::MAG_W+29:30];
		end
	end

	// Scaling and the two wheel sums, in Q24.
	logic [wtw_pkg::DIST_W-1:0] dist_q;
	logic signed [FW-1:0]       diff_q;
	logic signed [SW-1:0]       diff24, dist_e, left_sum_q, right_sum_q;

	assign diff24 = SW'(diff_q) <<< (16 - ANGLE_FRAC_BITS);
	assign dist_e = $signed(SW'(dist_q));

	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			dist_q <= wtw_pkg::DIST_W'(mag_q) * wtw_pkg::DIST_W'(dist_scale_q);
			diff_q <= FW'($signed({1'b0, turn_scale_q})) * FW'(delta_q);
		end
		if (cmd.sum) begin
			left_sum_q  <= dist_e - diff24;
			right_sum_q <= dist_e + diff24;
		end
	end

	// Truncate toward zero to whole ticks, then saturate.
	function automatic logic [wtw_pkg::TICKS_W:0] to_ticks(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] q;
		logic signed [wtw_pkg::TICKS_W-1:0] t;
		logic c;
		q = v[SW-1] ? ((v + $signed(SW'(24'hFFFFFF))) >>> 24) : (v >>> 24);
		c = 1'b0;
		priority if (q > wtw_pkg::TICK_LIMIT) begin
			t = wtw_pkg::TICKS_W'(wtw_pkg::TICK_LIMIT);
			c = 1'b1;
		end else if (q < -wtw_pkg::TICK_LIMIT) begin
			t = wtw_pkg::TICKS_W'(-wtw_pkg::TICK_LIMIT);
			c = 1'b1;
		end else begin
			t = q[wtw_pkg::TICKS_W-1:0];
		end
		return {c, t};
	endfunction

	logic [wtw_pkg::TICKS_W:0] left_r, right_r;

	assign left_r       = to_ticks(left_sum_q);
	assign right_r      = to_ticks(right_sum_q);
	assign sts.out_free = !out_valid || out_ready;

	// Output register: the next word may be accepted while this one waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.finish) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			left_ticks  <= $signed(left_r[wtw_pkg::TICKS_W-1:0]);
			right_ticks <= $signed(right_r[wtw_pkg::TICKS_W-1:0]);
			clipped     <= left_r[wtw_pkg::TICKS_W] || right_r[wtw_pkg::TICKS_W];
		end
	end

endmodule
